// ----- hw/rtl/atm_pkg.sv -----
// Shared types and constants for the ANSI text-mode terminal.
// Used by atm_ctrl, atm_dp, the top level and the testbench.
package atm_pkg;

  localparam int COLUMNS_DEF   = 80;
  localparam int ROWS_DEF      = 25;
  localparam int ESC_DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_FLUSH = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_PENDING = 2'd1,
    ST_APPLIED = 2'd2,
    ST_LITERAL = 2'd3
  } seq_st_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic boot;
    logic dispatch;
    logic parse;
    logic put;
    logic fill;
    logic scroll_start;
    logic scroll_rd;
    logic scroll_wr;
    logic print_next;
    logic read_cap;
  } atm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic go_parse;
    logic go_put;
    logic go_print;
    logic go_read;
    logic parse_fill;
    logic parse_print;
    logic put_fill;
    logic fill_last;
    logic need_scroll;
    logic scroll_last;
    logic print_more;
  } atm_sts_t;

endpackage

// ----- hw/rtl/atm_ctrl.sv -----
// Sequencer of the terminal: boot clear, dispatch, parse, put, fill, scroll, print, read.
// Depends on atm_pkg; drives atm_dp through atm_cmd_t.
module atm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  atm_pkg::atm_sts_t sts,
  output atm_pkg::atm_cmd_t cmd
);
  import atm_pkg::*;

  typedef enum logic [11:0] {
    S_BOOT  = 12'b0000_0000_0001,
    S_IDLE  = 12'b0000_0000_0010,
    S_DISP  = 12'b0000_0000_0100,
    S_PARSE = 12'b0000_0000_1000,
    S_PUT   = 12'b0000_0001_0000,
    S_CHK   = 12'b0000_0010_0000,
    S_FILL  = 12'b0000_0100_0000,
    S_SRD   = 12'b0000_1000_0000,
    S_SWR   = 12'b0001_0000_0000,
    S_PRINT = 12'b0010_0000_0000,
    S_READ  = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   boot_r, boot_nxt;
  logic   fchk_r, fchk_nxt;
  logic   print_r, print_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_BOOT;
      boot_r  <= 1'b1;
      fchk_r  <= 1'b0;
      print_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      boot_r  <= boot_nxt;
      fchk_r  <= fchk_nxt;
      print_r <= print_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    boot_nxt  = boot_r;
    fchk_nxt  = fchk_r;
    print_nxt = print_r;
    cmd       = '0;
    unique case (state_r)
      S_BOOT: begin
        cmd.boot  = 1'b1;
        state_nxt = S_FILL;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmd.dispatch = 1'b1;
        if (sts.go_parse) begin
          state_nxt = S_PARSE;
        end else if (sts.go_put) begin
          print_nxt = 1'b0;
          state_nxt = S_PUT;
        end else if (sts.go_print) begin
          print_nxt = 1'b1;
          state_nxt = S_PRINT;
        end else if (sts.go_read) begin
          state_nxt = S_READ;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_PARSE: begin
        cmd.parse = 1'b1;
        if (sts.parse_fill) begin
          fchk_nxt  = 1'b0;
          state_nxt = S_FILL;
        end else if (sts.parse_print) begin
          print_nxt = 1'b1;
          state_nxt = S_PRINT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_PUT: begin
        cmd.put = 1'b1;
        if (sts.put_fill) begin
          fchk_nxt  = 1'b1;
          state_nxt = S_FILL;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.need_scroll) begin
          cmd.scroll_start = 1'b1;
          state_nxt        = S_SRD;
        end else if (print_r) begin
          state_nxt = S_PRINT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (sts.fill_last) begin
          if (boot_r) begin
            boot_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else if (fchk_r) begin
            state_nxt = S_CHK;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_SRD: begin
        cmd.scroll_rd = 1'b1;
        state_nxt     = S_SWR;
      end
      S_SWR: begin
        cmd.scroll_wr = 1'b1;
        if (sts.scroll_last) begin
          fchk_nxt  = 1'b1;
          state_nxt = S_FILL;
        end else begin
          state_nxt = S_SRD;
        end
      end
      S_PRINT: begin
        cmd.print_next = 1'b1;
        state_nxt      = sts.print_more ? S_PUT : S_OUT;
      end
      S_READ: begin
        cmd.read_cap = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_BOOT;
    endcase
  end

endmodule

// ----- hw/rtl/atm_dp.sv -----
// Datapath of the terminal: screen memory, cursor, attribute, escape buffer and parser.
// Depends on atm_pkg; commanded by atm_ctrl.
module atm_dp #(
  parameter int COLUMNS      = atm_pkg::COLUMNS_DEF,
  parameter int ROWS         = atm_pkg::ROWS_DEF,
  parameter int ESCAPE_DEPTH = atm_pkg::ESC_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  atm_pkg::atm_cmd_t          cmd,
  output atm_pkg::atm_sts_t          sts,
  input  logic [1:0]                 in_cmd,
  input  logic [7:0]                 in_char_code,
  input  logic [10:0]                in_cell_index,
  output logic [15:0]                cell_value,
  output logic [$clog2(COLUMNS)-1:0] col_now,
  output logic [$clog2(ROWS+1)-1:0]  row_now,
  output logic [1:0]                 seq_status
);
  import atm_pkg::*;

  localparam int CELLS   = COLUMNS * ROWS;
  localparam int SCR_END = COLUMNS * (ROWS - 1);
  localparam int AW      = $clog2(CELLS + 1);
  localparam int MAW     = $clog2(CELLS);
  localparam int CW      = $clog2(COLUMNS);
  localparam int TW      = $clog2(2 * COLUMNS + 1);
  localparam int RW      = $clog2(ROWS + 1);
  localparam int PW      = $clog2(ESCAPE_DEPTH + 1);
  localparam int PIW     = $clog2(ESCAPE_DEPTH);
  localparam int SW      = 11;

  localparam logic [7:0] CH_ESC  = 8'h1b;
  localparam logic [7:0] CH_LBR  = 8'h5b;
  localparam logic [7:0] CH_SEMI = 8'h3b;
  localparam logic [7:0] CH_NL   = 8'h0a;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_H    = 8'h48;
  localparam logic [7:0] CH_J    = 8'h4a;
  localparam logic [7:0] CH_K    = 8'h4b;
  localparam logic [7:0] CH_F    = 8'h66;
  localparam logic [7:0] CH_M    = 8'h6d;
  localparam logic [7:0] CH_S    = 8'h73;
  localparam logic [7:0] CH_U    = 8'h75;

  localparam logic [9:0] NUM_MAX  = 10'd999;
  localparam logic [7:0] ATTR_RST = 8'h07;

  typedef enum logic [1:0] {
    PR_MORE = 2'd0,
    PR_DONE = 2'd1,
    PR_REJ  = 2'd2
  } parse_res_t;

  // ANSI colour order to VGA order is a 3-bit reversal
  function automatic logic [2:0] palette(input logic [2:0] i);
    return {i[0], i[1], i[2]};
  endfunction

  // {accepted, new attribute}
  function automatic logic [8:0] sgr_apply(input logic [7:0] a, input logic [9:0] n);
    logic [9:0] d30;
    logic [9:0] d40;
    logic [8:0] r;
    d30 = n - 10'd30;
    d40 = n - 10'd40;
    r   = {1'b1, a};
    if (n == 10'd0) r[7:0] = a & 8'h77;
    else if (n == 10'd1) r[7:0] = a | 8'h08;
    else if (n == 10'd5) r[7:0] = a | 8'h80;
    else if (n >= 10'd30 && n <= 10'd37) r[7:0] = {a[7:3], palette(d30[2:0])};
    else if (n >= 10'd40 && n <= 10'd47) r[7:0] = {a[7], palette(d40[2:0]), a[3:0]};
    else r = {1'b0, a};
    return r;
  endfunction

  // control state
  logic [CW-1:0] col_r, scol_r;
  logic [RW-1:0] row_r, srow_r;
  logic [7:0]    attr_r, prev_r;
  logic [PW-1:0] cnt_r, pidx_r, pn_r;
  logic [9:0]    n1_r, n2_r;
  logic [2:0]    flags_r;

  // payload
  logic [1:0]    item_cmd_r;
  logic [7:0]    item_char_r, cur_r;
  logic [10:0]   item_idx_r;
  logic [AW-1:0] ptr_r, end_r;
  logic [15:0]   val_r, rdata_r;
  logic [1:0]    status_r;
  logic [7:0]    pend_r [ESCAPE_DEPTH];
  logic [15:0]   mem    [CELLS];

  // shared
  logic [AW-1:0] base, cur_addr, line_end;
  logic          idx_ok;

  // parser
  logic          h1, h2, dl, plain_num, none_seen, pos_ge2, is_dig, is_semi, parse_last;
  logic [3:0]    dig;
  logic [9:0]    n_sel, n_sat;
  logic [13:0]   n_prod;
  logic [8:0]    sgr1, sgr2;
  parse_res_t    res;
  logic [SW-1:0] n1_s, n2_s, row_s, col_s, row_dn_s, col_rt_s;
  logic [RW-1:0] row_up, row_dn, row_h;
  logic [CW-1:0] col_rt, col_lt, col_h;

  // put
  logic [TW-1:0] tgt, tgt_cl, col_pre;
  logic          row_inc, wrap, put_fill, put_char;
  logic [AW-1:0] fs, fe;
  logic [CW-1:0] col_new;
  logic [RW-1:0] row_new;

  // memory ports
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic [MAW-1:0] raddr;

  assign base     = AW'(row_r) * AW'(COLUMNS);
  assign cur_addr = base + AW'(col_r);
  assign line_end = base + AW'(COLUMNS);
  assign idx_ok   = 32'(item_idx_r) < CELLS;

  always_comb begin
    h1         = flags_r[0];
    h2         = flags_r[1];
    dl         = flags_r[2];
    plain_num  = !dl && h1 && !h2;
    none_seen  = !dl && !h1 && !h2;
    pos_ge2    = cnt_r >= PW'(2);
    is_dig     = (item_char_r >= CH_0) && (item_char_r <= CH_9);
    is_semi    = item_char_r == CH_SEMI;
    dig        = 4'(item_char_r - CH_0);
    n_sel      = dl ? n2_r : n1_r;
    n_prod     = 14'(n_sel) * 14'd10 + 14'(dig);
    n_sat      = (n_prod > 14'(NUM_MAX)) ? NUM_MAX : n_prod[9:0];
    sgr1       = sgr_apply(attr_r, n1_r);
    sgr2       = sgr_apply(sgr1[7:0], n2_r);
    parse_last = cnt_r == PW'(ESCAPE_DEPTH - 1);

    res = PR_REJ;
    if (cnt_r == '0) begin
      res = (item_char_r == CH_ESC) ? PR_MORE : PR_REJ;
    end else if (cnt_r == PW'(1)) begin
      res = (item_char_r == CH_LBR) ? PR_MORE : PR_REJ;
    end else if (is_dig) begin
      res = PR_MORE;
    end else begin
      unique case (item_char_r)
        CH_SEMI:                  res = dl ? PR_REJ : PR_MORE;
        CH_A, CH_B, CH_C, CH_D:   res = plain_num ? PR_DONE : PR_REJ;
        CH_H, CH_F:               res = (h1 && h2) ? PR_DONE : PR_REJ;
        CH_J:                     res = (plain_num && n1_r == 10'd2) ? PR_DONE : PR_REJ;
        CH_K, CH_S, CH_U:         res = none_seen ? PR_DONE : PR_REJ;
        CH_M:                     res = (h1 && sgr1[8] && (!h2 || sgr2[8])) ? PR_DONE : PR_REJ;
        default:                  res = PR_REJ;
      endcase
    end

    n1_s     = SW'(n1_r);
    n2_s     = SW'(n2_r);
    row_s    = SW'(row_r);
    col_s    = SW'(col_r);
    row_dn_s = row_s + n1_s;
    col_rt_s = col_s + n1_s;
    row_up   = (n1_s >= row_s) ? '0 : RW'(row_s - n1_s);
    row_dn   = (row_dn_s >= SW'(ROWS)) ? RW'(ROWS - 1) : RW'(row_dn_s);
    col_rt   = (col_rt_s >= SW'(COLUMNS)) ? CW'(COLUMNS - 1) : CW'(col_rt_s);
    col_lt   = (n1_s >= col_s) ? '0 : CW'(col_s - n1_s);
    row_h    = (n1_s >= SW'(ROWS)) ? RW'(ROWS - 1) : RW'(n1_r);
    col_h    = (n2_s >= SW'(COLUMNS)) ? CW'(COLUMNS - 1) : CW'(n2_r);
  end

  always_comb begin
    tgt      = (TW'(col_r) & ~TW'(7)) + TW'(8);
    tgt_cl   = (tgt > TW'(COLUMNS)) ? TW'(COLUMNS) : tgt;
    col_pre  = TW'(col_r) + TW'(1);
    row_inc  = 1'b0;
    put_fill = 1'b0;
    put_char = 1'b0;
    fs       = cur_addr;
    fe       = line_end;
    unique case (cur_r)
      CH_NL: begin
        col_pre  = '0;
        row_inc  = 1'b1;
        put_fill = prev_r != CH_CR;
      end
      CH_CR: col_pre = '0;
      CH_TAB: begin
        col_pre  = tgt;
        put_fill = 1'b1;
        fe       = base + AW'(tgt_cl);
      end
      default: put_char = 1'b1;
    endcase
    wrap    = col_pre >= TW'(COLUMNS);
    col_new = wrap ? CW'(col_pre - TW'(COLUMNS)) : CW'(col_pre);
    row_new = row_r + RW'(row_inc | wrap);
  end

  always_comb begin
    we    = 1'b0;
    waddr = ptr_r;
    wdata = {attr_r, 8'h00};
    if (cmd.fill) begin
      we = 1'b1;
    end else if (cmd.scroll_wr) begin
      we    = 1'b1;
      wdata = rdata_r;
    end else if (cmd.put && put_char) begin
      we    = 1'b1;
      waddr = cur_addr;
      wdata = {attr_r, cur_r};
    end
    raddr = cmd.scroll_rd ? MAW'(ptr_r + AW'(COLUMNS)) : MAW'(item_idx_r);
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr[MAW-1:0]] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.parse) pend_r[cnt_r[PIW-1:0]] <= item_char_r;
  end

  always_comb begin
    sts.go_parse    = (item_cmd_r == CMD_PUT) && (item_char_r == CH_ESC || cnt_r != '0);
    sts.go_put      = (item_cmd_r == CMD_PUT) && !sts.go_parse;
    sts.go_print    = (item_cmd_r == CMD_FLUSH) && cnt_r != '0;
    sts.go_read     = item_cmd_r == CMD_READ;
    sts.parse_fill  = (res == PR_DONE) && (item_char_r == CH_J || item_char_r == CH_K);
    sts.parse_print = (res == PR_REJ) || (res == PR_MORE && parse_last);
    sts.put_fill    = put_fill;
    sts.fill_last   = AW'(ptr_r + AW'(1)) == end_r;
    sts.need_scroll = row_r >= RW'(ROWS);
    sts.scroll_last = ptr_r == AW'(SCR_END - 1);
    sts.print_more  = pidx_r < pn_r;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_cmd_r  <= in_cmd;
      item_char_r <= in_char_code;
      item_idx_r  <= in_cell_index;
    end
    if (cmd.dispatch) begin
      cur_r <= item_char_r;
      val_r <= '0;
      unique case (cmd_t'(item_cmd_r))
        CMD_PUT:           status_r <= ST_IDLE;
        CMD_FLUSH:         status_r <= (cnt_r != '0) ? ST_LITERAL : ST_IDLE;
        CMD_READ, CMD_NOP: status_r <= (cnt_r != '0) ? ST_PENDING : ST_IDLE;
        default:           status_r <= ST_IDLE;
      endcase
    end
    if (cmd.parse) begin
      if (res == PR_DONE) status_r <= ST_APPLIED;
      else if (sts.parse_print) status_r <= ST_LITERAL;
      else status_r <= ST_PENDING;
    end
    if (cmd.read_cap) val_r <= idx_ok ? rdata_r : 16'h0000;
    if (cmd.print_next && sts.print_more) cur_r <= pend_r[pidx_r[PIW-1:0]];

    if (cmd.boot) begin
      ptr_r <= '0;
      end_r <= AW'(CELLS);
    end else if (cmd.parse) begin
      if (item_char_r == CH_J) begin
        ptr_r <= '0;
        end_r <= AW'(CELLS);
      end else begin
        ptr_r <= cur_addr;
        end_r <= line_end;
      end
    end else if (cmd.put) begin
      ptr_r <= fs;
      end_r <= fe;
    end else if (cmd.fill) begin
      ptr_r <= ptr_r + AW'(1);
    end else if (cmd.scroll_start) begin
      ptr_r <= '0;
    end else if (cmd.scroll_wr) begin
      if (sts.scroll_last) begin
        ptr_r <= AW'(SCR_END);
        end_r <= AW'(CELLS);
      end else begin
        ptr_r <= ptr_r + AW'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      scol_r  <= '0;
      srow_r  <= '0;
      attr_r  <= ATTR_RST;
      prev_r  <= '0;
      cnt_r   <= '0;
      pidx_r  <= '0;
      pn_r    <= '0;
      n1_r    <= '0;
      n2_r    <= '0;
      flags_r <= '0;
    end else begin
      if (cmd.dispatch && sts.go_print) begin
        pn_r    <= cnt_r;
        pidx_r  <= '0;
        cnt_r   <= '0;
        n1_r    <= '0;
        n2_r    <= '0;
        flags_r <= '0;
      end
      if (cmd.parse) begin
        if (pos_ge2 && item_char_r == CH_M && h1 && sgr1[8]) begin
          attr_r <= (h2 && sgr2[8]) ? sgr2[7:0] : sgr1[7:0];
        end
        if (res == PR_DONE) begin
          cnt_r   <= '0;
          n1_r    <= '0;
          n2_r    <= '0;
          flags_r <= '0;
          unique case (item_char_r)
            CH_A:       row_r <= row_up;
            CH_B:       row_r <= row_dn;
            CH_C:       col_r <= col_rt;
            CH_D:       col_r <= col_lt;
            CH_H, CH_F: begin
              row_r <= row_h;
              col_r <= col_h;
            end
            CH_J: begin
              row_r <= '0;
              col_r <= '0;
            end
            CH_S: begin
              scol_r <= col_r;
              srow_r <= row_r;
            end
            CH_U: begin
              col_r <= scol_r;
              row_r <= srow_r;
            end
            default: ;
          endcase
        end else if (sts.parse_print) begin
          pn_r    <= cnt_r + PW'(1);
          pidx_r  <= '0;
          cnt_r   <= '0;
          n1_r    <= '0;
          n2_r    <= '0;
          flags_r <= '0;
        end else begin
          cnt_r <= cnt_r + PW'(1);
          if (pos_ge2 && is_dig) begin
            if (dl) begin
              n2_r       <= n_sat;
              flags_r[1] <= 1'b1;
            end else begin
              n1_r       <= n_sat;
              flags_r[0] <= 1'b1;
            end
          end
          if (pos_ge2 && is_semi) flags_r[2] <= 1'b1;
        end
      end
      if (cmd.put) begin
        col_r  <= col_new;
        row_r  <= row_new;
        prev_r <= cur_r;
      end
      if (cmd.scroll_wr && sts.scroll_last) row_r <= row_r - RW'(1);
      if (cmd.print_next && sts.print_more) pidx_r <= pidx_r + PW'(1);
    end
  end

  assign cell_value = val_r;
  assign col_now    = col_r;
  assign row_now    = row_r;
  assign seq_status = status_r;

endmodule

// ----- hw/rtl/ansi_text_mode_terminal.sv -----
// Channel  Dir  Handshake            Payload
// in       in   in_valid / in_stall  in_cmd, in_char_code, in_cell_index
// out      out  out_valid / out_stall out_cell_value, out_cursor_column, out_cursor_row,
//                                    out_seq_status
// One item at a time, one result per item. A plain character goes through the dispatch,
// put and check states to its result, an escape byte through dispatch and parse, a read
// through dispatch and read, a flush with nothing pending or a no-op through dispatch only.
// Line, tab and screen clears write one cell at a time through the single memory write port;
// a scroll copies COLUMNS*(ROWS-1) cells, reading then writing each, plus a line of blanks.
// Printing a sequence repeats the put path per byte; after reset the screen is cleared
// with in_stall high. A stalled result holds the block; in_stall is low only when idle.
// Depends on atm_pkg, atm_ctrl and atm_dp.
module ansi_text_mode_terminal #(
  parameter int COLUMNS      = atm_pkg::COLUMNS_DEF,
  parameter int ROWS         = atm_pkg::ROWS_DEF,
  parameter int ESCAPE_DEPTH = atm_pkg::ESC_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_char_code,
  input  logic [10:0] in_cell_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_cell_value,
  output logic [6:0]  out_cursor_column,
  output logic [4:0]  out_cursor_row,
  output logic [1:0]  out_seq_status
);
  import atm_pkg::*;

  atm_cmd_t                     cmd;
  atm_sts_t                     sts;
  logic [$clog2(COLUMNS)-1:0]   col_now;
  logic [$clog2(ROWS+1)-1:0]    row_now;

  atm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  atm_dp #(
    .COLUMNS      (COLUMNS),
    .ROWS         (ROWS),
    .ESCAPE_DEPTH (ESCAPE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_cmd        (in_cmd),
    .in_char_code  (in_char_code),
    .in_cell_index (in_cell_index),
    .cell_value    (out_cell_value),
    .col_now       (col_now),
    .row_now       (row_now),
    .seq_status    (out_seq_status)
  );

  assign out_cursor_column = 7'(col_now);
  assign out_cursor_row    = 5'(row_now);

endmodule

// ----- hw/rtl/atm_chk.sv -----
// Port checker for ansi_text_mode_terminal, bound to the top level.
// Depends on the top-level ports only.
module atm_chk #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_cell_value,
  input logic [6:0]  out_cursor_column,
  input logic [4:0]  out_cursor_row,
  input logic [1:0]  out_seq_status
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cell_value)
      && $stable(out_seq_status))
    else $error("result changed while stalled");

  // one item in flight: a transfer closes the input until the result is gone
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input reopened before result");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while result waits");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_cursor_column) < COLUMNS) && (32'(out_cursor_row) < ROWS))
    else $error("cursor off screen");

endmodule

bind ansi_text_mode_terminal atm_chk #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_atm_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_cell_value    (out_cell_value),
  .out_cursor_column (out_cursor_column),
  .out_cursor_row    (out_cursor_row),
  .out_seq_status    (out_seq_status)
);

// ----- dv/ansi_text_mode_terminal_tb.sv -----
// Self-checking testbench for ansi_text_mode_terminal: a directed table, then random
// character streams and escape sequences, each result checked against an in-bench screen model.
// Depends on atm_pkg and the terminal RTL.
`timescale 1ns / 100ps

module ansi_text_mode_terminal_tb;
  import atm_pkg::*;

  localparam int COLS  = 80;
  localparam int ROWS  = 25;
  localparam int DEPTH = 16;
  localparam int CELLS = COLS * ROWS;
  localparam logic [7:0] ESC = 8'h1b;
  localparam int CYCLE_LIMIT = 4_000_000;

  typedef enum int {
    P_MORE = 0,
    P_DONE = 1,
    P_REJ  = 2
  } parse_t;

  typedef struct {
    cmd_t        cmd;
    logic [7:0]  ch;
    logic [10:0] idx;
    bit          typed;
    logic [15:0] e_val;
    logic [6:0]  e_col;
    logic [4:0]  e_row;
    seq_st_t     e_st;
  } row_t;

  typedef struct {
    logic [15:0] val;
    logic [6:0]  col;
    logic [4:0]  row;
    seq_st_t     st;
  } term_res_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_stall = 0;
  logic [1:0] in_cmd = 0;
  logic [7:0] in_char_code = 0;
  logic [10:0] in_cell_index = 0;
  logic in_stall, out_valid;
  logic [15:0] out_cell_value;
  logic [6:0] out_cursor_column;
  logic [4:0] out_cursor_row;
  logic [1:0] out_seq_status;

  ansi_text_mode_terminal dut (.*);

  always #6 clk = ~clk;

  // terminal shadow state
  logic [15:0] scr [CELLS];
  logic [7:0] pend [DEPTH];
  int pcnt, num1, num2;
  bit has1, has2, delim;
  int cur_c, cur_r, sav_c, sav_r;
  logic [7:0] attr, prev_ch;
  const int pal [8] = '{0, 4, 2, 6, 1, 5, 3, 7};

  term_res_t due_q[$];
  int errors = 0;
  bit quiet = 0;
  bit hold_long = 0;
  longint cycles = 0;

  function automatic void span_clear(int from, int upto);
    if (upto > COLS) upto = COLS;
    for (int i = from; i < upto; i++) scr[cur_r * COLS + i] = {attr, 8'h00};
  endfunction

  function automatic void put_plain(logic [7:0] c);
    int t;
    if (c == 8'h0a) begin
      if (prev_ch != 8'h0d) span_clear(cur_c, COLS);
      cur_c = 0;
      cur_r++;
    end else if (c == 8'h0d) begin
      cur_c = 0;
    end else if (c == 8'h09) begin
      t = (cur_c & ~7) + 8;
      span_clear(cur_c, t);
      cur_c = t;
    end else begin
      scr[cur_r * COLS + cur_c] = {attr, c};
      cur_c++;
    end
    if (cur_c >= COLS) begin
      cur_r += cur_c / COLS;
      cur_c %= COLS;
    end
    while (cur_r >= ROWS) begin
      for (int i = 0; i < COLS * (ROWS - 1); i++) scr[i] = scr[i + COLS];
      for (int i = COLS * (ROWS - 1); i < CELLS; i++) scr[i] = {attr, 8'h00};
      cur_r--;
    end
    prev_ch = c;
  endfunction

  function automatic void seq_end();
    pcnt = 0; num1 = 0; num2 = 0; has1 = 0; has2 = 0; delim = 0;
  endfunction

  function automatic void print_pend();
    int n = pcnt > DEPTH ? DEPTH : pcnt;
    for (int i = 0; i < n; i++) put_plain(pend[i]);
    seq_end();
  endfunction

  function automatic bit sgr(int n);
    if (n == 0) attr &= 8'h77;
    else if (n == 1) attr |= 8'h08;
    else if (n == 5) attr |= 8'h80;
    else if (n >= 30 && n <= 37) attr = (attr & 8'hf8) | 8'(pal[n - 30]);
    else if (n >= 40 && n <= 47) attr = (attr & 8'h8f) | 8'(pal[n - 40] << 4);
    else return 0;
    return 1;
  endfunction

  function automatic parse_t parse_esc(int pos, logic [7:0] c);
    bit pn = !delim && has1 && !has2;
    bit none = !delim && !has1 && !has2;
    if (pos == 0) return c == ESC ? P_MORE : P_REJ;
    if (pos == 1) return c == "[" ? P_MORE : P_REJ;
    if (c >= "0" && c <= "9") begin
      if (!delim) begin
        num1 = num1 * 10 + (c - "0"); if (num1 > 999) num1 = 999; has1 = 1;
      end else begin
        num2 = num2 * 10 + (c - "0"); if (num2 > 999) num2 = 999; has2 = 1;
      end
      return P_MORE;
    end
    case (c)
      ";": begin if (delim) return P_REJ; delim = 1; return P_MORE; end
      "A": begin
        if (!pn) return P_REJ; cur_r = num1 >= cur_r ? 0 : cur_r - num1; return P_DONE;
      end
      "B": begin
        if (!pn) return P_REJ;
        cur_r = cur_r + num1 >= ROWS ? ROWS - 1 : cur_r + num1; return P_DONE;
      end
      "C": begin
        if (!pn) return P_REJ;
        cur_c = cur_c + num1 >= COLS ? COLS - 1 : cur_c + num1; return P_DONE;
      end
      "D": begin
        if (!pn) return P_REJ; cur_c = num1 >= cur_c ? 0 : cur_c - num1; return P_DONE;
      end
      "H", "f": begin
        if (!has1 || !has2) return P_REJ;
        cur_r = num1 >= ROWS ? ROWS - 1 : num1;
        cur_c = num2 >= COLS ? COLS - 1 : num2;
        return P_DONE;
      end
      "J": begin
        if (!pn || num1 != 2) return P_REJ;
        for (int i = 0; i < CELLS; i++) scr[i] = {attr, 8'h00};
        cur_c = 0; cur_r = 0;
        return P_DONE;
      end
      "K": begin if (!none) return P_REJ; span_clear(cur_c, COLS); return P_DONE; end
      "m": begin
        if (!has1 || !sgr(num1)) return P_REJ;
        if (has2 && !sgr(num2)) return P_REJ;
        return P_DONE;
      end
      "s": begin if (!none) return P_REJ; sav_c = cur_c; sav_r = cur_r; return P_DONE; end
      "u": begin if (!none) return P_REJ; cur_c = sav_c; cur_r = sav_r; return P_DONE; end
      default: return P_REJ;
    endcase
  endfunction

  function automatic term_res_t term_step(cmd_t cmd, logic [7:0] c, logic [10:0] idx);
    term_res_t r;
    int pos;
    parse_t p;
    r.val = 0;
    r.st = ST_IDLE;
    if (cmd == CMD_PUT) begin
      if (c == ESC || pcnt > 0) begin
        pos = pcnt >= DEPTH ? DEPTH - 1 : pcnt;
        pend[pos] = c;
        pcnt = pos + 1;
        p = parse_esc(pos, c);
        if (p == P_DONE) begin
          seq_end(); r.st = ST_APPLIED;
        end else if (p == P_REJ || pcnt >= DEPTH) begin
          print_pend(); r.st = ST_LITERAL;
        end else begin
          r.st = ST_PENDING;
        end
      end else begin
        put_plain(c);
      end
    end else if (cmd == CMD_FLUSH) begin
      if (pcnt > 0) begin
        print_pend(); r.st = ST_LITERAL;
      end
    end else begin
      if (cmd == CMD_READ && idx < CELLS) r.val = scr[idx];
      r.st = pcnt > 0 ? ST_PENDING : ST_IDLE;
    end
    r.col = 7'(cur_c);
    r.row = 5'(cur_r);
    return r;
  endfunction

  // stimulus store
  cmd_t s_cmd[$];
  logic [7:0] s_ch[$];
  logic [10:0] s_idx[$];

  task automatic push(cmd_t c, logic [7:0] ch, logic [10:0] idx);
    s_cmd.push_back(c); s_ch.push_back(ch); s_idx.push_back(idx);
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) push(CMD_PUT, s[i], 11'($urandom));
  endtask

  task automatic push_rand_seq();
    string s;
    int k;
    s = "";
    k = $urandom_range(0, 13);
    case (k)
      0: s = $sformatf("[%0dA", $urandom_range(0, 30));
      1: s = $sformatf("[%0dB", $urandom_range(0, 30));
      2: s = $sformatf("[%0dC", $urandom_range(0, 90));
      3: s = $sformatf("[%0dD", $urandom_range(0, 90));
      4: s = $sformatf("[%0d;%0d%s", $urandom_range(0, 30), $urandom_range(0, 90),
                       $urandom_range(0, 1) ? "H" : "f");
      5: s = "[2J";
      6: s = "[K";
      7: s = $sformatf("[%0dm", $urandom_range(0, 49));
      8: s = $sformatf("[%0d;%0dm", $urandom_range(30, 37), $urandom_range(40, 48));
      9: s = "[s";
      10: s = "[u";
      11: s = $sformatf("[%0d%c", $urandom_range(0, 99999), 8'($urandom_range(32, 126)));
      12: s = "[1;2;3m";
      default: s = $sformatf("%c", 8'($urandom));
    endcase
    push(CMD_PUT, ESC, 11'($urandom));
    if (k == 5 && $urandom_range(0, 3) != 0) begin
      s = "[K";
    end
    push_str(s);
    if ($urandom_range(0, 9) == 0) push(CMD_FLUSH, 8'($urandom), 11'($urandom));
  endtask

  row_t dir_tbl[$];

  task automatic add_row(cmd_t c, logic [7:0] ch, logic [10:0] idx, bit typed = 0,
                         logic [15:0] v = 0, logic [6:0] col = 0, logic [4:0] r = 0,
                         seq_st_t st = ST_IDLE);
    row_t t;
    t.cmd = c; t.ch = ch; t.idx = idx; t.typed = typed;
    t.e_val = v; t.e_col = col; t.e_row = r; t.e_st = st;
    dir_tbl.push_back(t);
  endtask

  // sender: valid stays high from one transfer to the next unless an idle burst is drawn
  task automatic send_one(cmd_t c, logic [7:0] ch, logic [10:0] idx);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1;
    in_cmd <= c;
    in_char_code <= ch;
    in_cell_index <= idx;
    do @(posedge clk); while (in_stall);
    due_q.push_back(term_step(c, ch, idx));
  endtask

  // receiver stall
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1;
        repeat (300) @(posedge clk);
        out_stall <= 0;
        hold_long = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  // checker
  always @(posedge clk) begin
    term_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (due_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = due_q.pop_front();
        if (out_cell_value !== e.val) begin
          $error("cell_value exp %h got %h", e.val, out_cell_value); errors++;
        end
        if (out_cursor_column !== e.col) begin
          $error("cursor_column exp %0d got %0d", e.col, out_cursor_column); errors++;
        end
        if (out_cursor_row !== e.row) begin
          $error("cursor_row exp %0d got %0d", e.row, out_cursor_row); errors++;
        end
        if (out_seq_status !== e.st) begin
          $error("seq_status exp %0d got %0d", e.st, out_seq_status); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    row_t t;
    term_res_t e;
    int n;
    for (int i = 0; i < CELLS; i++) scr[i] = 16'h0700;
    for (int i = 0; i < DEPTH; i++) pend[i] = 0;
    seq_end();
    cur_c = 0; cur_r = 0; sav_c = 0; sav_r = 0; attr = 8'h07; prev_ch = 0;

    add_row(CMD_READ, 8'h00, 11'd0, 1'b1, 16'h0700, 7'd0, 5'd0, ST_IDLE);
    add_row(CMD_READ, 8'hff, 11'd1999, 1'b1, 16'h0700, 7'd0, 5'd0, ST_IDLE);
    add_row(CMD_READ, 8'h00, 11'd2047, 1'b1, 16'h0000, 7'd0, 5'd0, ST_IDLE);
    add_row(CMD_FLUSH, 8'h00, 11'd0, 1'b1, 16'h0000, 7'd0, 5'd0, ST_IDLE);
    add_row(CMD_NOP, 8'hff, 11'h7ff, 1'b1, 16'h0000, 7'd0, 5'd0, ST_IDLE);
    add_row(CMD_PUT, 8'hff, 11'd0);
    add_row(CMD_PUT, 8'h00, 11'd0);
    add_row(CMD_READ, 8'h00, 11'd0, 1'b1, 16'h07ff, 7'd2, 5'd0, ST_IDLE);
    add_row(CMD_PUT, 8'h09, 11'd0);
    add_row(CMD_PUT, 8'h0d, 11'd0);
    add_row(CMD_PUT, 8'h0a, 11'd0);
    add_row(CMD_PUT, 8'h0a, 11'd0);
    add_row(CMD_PUT, ESC, 11'd0, 1'b1, 16'h0000, 7'd0, 5'd2, ST_PENDING);
    add_row(CMD_FLUSH, 8'h00, 11'd0);
    add_row(CMD_PUT, ESC, 11'd0);
    add_row(CMD_PUT, "x", 11'd0);
    // typed rows pin the shadow model down before it predicts the block
    foreach (dir_tbl[i]) begin
      t = dir_tbl[i];
      e = term_step(t.cmd, t.ch, t.idx);
      if (t.typed) begin
        if (e.val !== t.e_val) begin
          $error("cell_value exp %h got %h", t.e_val, e.val); errors++;
        end
        if (e.col !== t.e_col) begin
          $error("cursor_column exp %0d got %0d", t.e_col, e.col); errors++;
        end
        if (e.row !== t.e_row) begin
          $error("cursor_row exp %0d got %0d", t.e_row, e.row); errors++;
        end
        if (e.st !== t.e_st) begin
          $error("seq_status exp %0d got %0d", t.e_st, e.st); errors++;
        end
      end
    end
    // back to the reset state for the live run
    for (int i = 0; i < CELLS; i++) scr[i] = 16'h0700;
    seq_end();
    cur_c = 0; cur_r = 0; sav_c = 0; sav_r = 0; attr = 8'h07; prev_ch = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (dir_tbl[i]) send_one(dir_tbl[i].cmd, dir_tbl[i].ch, dir_tbl[i].idx);
    // sequences of every kind, numbers beyond 999, overlong sequence
    push_str("\033[2;5H\033[3A\033[99B\033[200C\033[999D\033[12345;67890f");
    push_str("\033[5;9H\033[s\033[H\033[u\033[1;5m\033[31;44mX\033[0m\033[38mY");
    push_str("\033[2J\033[K\033[;5H\033[1;2;\033[0123456789012345678");
    for (int i = 0; i < 40; i++) push(CMD_PUT, 8'h0a, 11'd0);
    for (int i = 0; i < 2; i++) push(CMD_PUT, 8'h09, 11'd0);
    foreach (s_cmd[i]) send_one(s_cmd[i], s_ch[i], s_idx[i]);
    s_cmd.delete(); s_ch.delete(); s_idx.delete();

    // long receiver hold while offering items
    hold_long = 1;
    for (int i = 0; i < 6; i++) send_one(CMD_PUT, 8'h41 + 8'(i), 11'd0);

    n = 0;
    while (n < 220) begin
      case ($urandom_range(0, 9))
        0, 1, 2: push_rand_seq();
        3: push(CMD_READ, 8'($urandom), 11'($urandom_range(0, 2047)));
        4: push(cmd_t'($urandom_range(1, 3)), 8'($urandom), 11'($urandom));
        5: push(CMD_PUT, 8'($urandom), 11'($urandom));
        6: push(CMD_PUT, $urandom_range(0, 3) == 0 ? 8'h0a : 8'h0d, 11'($urandom));
        default: push(CMD_PUT, 8'($urandom_range(32, 126)), 11'($urandom));
      endcase
      while (s_cmd.size() > 0) begin
        if (n > 180) quiet = 1;
        send_one(s_cmd.pop_front(), s_ch.pop_front(), s_idx.pop_front());
        n++;
      end
    end
    in_valid <= 0;

    while (due_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
